>>> hw/rtl/qvr_pkg.sv
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int FIELD_W = 16;
  // conjugate components need one bit more than a field
  localparam int CONJ_W = FIELD_W + 1;

  typedef enum logic {
    CMD_ROTATE  = 1'b0,
    CMD_PRODUCT = 1'b1
  } qvr_cmd_t;

  typedef struct packed {
    qvr_cmd_t                   cmd;
    logic signed [FIELD_W-1:0]  qa_w;
    logic signed [FIELD_W-1:0]  qa_x;
    logic signed [FIELD_W-1:0]  qa_y;
    logic signed [FIELD_W-1:0]  qa_z;
    logic signed [FIELD_W-1:0]  b_w;
    logic signed [FIELD_W-1:0]  b_x;
    logic signed [FIELD_W-1:0]  b_y;
    logic signed [FIELD_W-1:0]  b_z;
  } qvr_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]  r_w;
    logic signed [FIELD_W-1:0]  r_x;
    logic signed [FIELD_W-1:0]  r_y;
    logic signed [FIELD_W-1:0]  r_z;
  } qvr_rsp_t;

endpackage

>>> hw/rtl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps

// fixed-point quaternion unit: vector rotation q*(0,v)*conj(q) or hamilton product
// request channel req_valid/req_ready/req carries cmd, quaternion qa and operand b;
// cmd rotate reads b_x/b_y/b_z as a Q8.8 vector and ignores b_w, cmd product reads
// b as a Q2.14 quaternion. response channel rsp_valid/rsp_ready/rsp gives one word
// per request, in order; r_w is zero for rotations
// pipeline: products, sums, round/saturate for t = qa*b, then products, sums,
// round/saturate for t*conj(qa), then the output register - seven stages
// each accepted word moves through these registers in order to the output register
// and is held on rsp until it is taken at an edge with rsp_ready high
// throughput: one word per cycle while rsp_ready is high, set by the per-stage
// valid/ready chain; each product stage's sixteen multipliers are fully parallel
// stall: holding rsp_ready low freezes the output word; upstream stages keep
// filling bubbles and req_ready drops only once all seven stages hold a word
// reset: rst is synchronous and clears every stage valid; no state survives items
module quaternion_vector_rotate #(
  parameter int COMP_WIDTH     = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  qvr_pkg::qvr_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output qvr_pkg::qvr_rsp_t rsp
);

  import qvr_pkg::*;

  localparam int CW    = COMP_WIDTH;
  localparam int TW    = COMP_WIDTH + 4;
  localparam int P1_W  = 2 * FIELD_W;
  localparam int S1_W  = P1_W + 2;
  localparam int P2_W  = TW + CONJ_W;
  localparam int S2_W  = P2_W + 2;
  localparam int SD1_W = 1 + 4 * FIELD_W;
  localparam int SD2_W = 1 + 4 * CW;

  // first product qa * b
  logic signed [FIELD_W-1:0] qa_arr [4];
  logic signed [FIELD_W-1:0] b_arr [4];
  logic [SD1_W-1:0]          side_req;

  assign qa_arr[0] = req.qa_w;
  assign qa_arr[1] = req.qa_x;
  assign qa_arr[2] = req.qa_y;
  assign qa_arr[3] = req.qa_z;
  assign b_arr[0]  = (req.cmd == CMD_ROTATE) ? '0 : req.b_w;
  assign b_arr[1]  = req.b_x;
  assign b_arr[2]  = req.b_y;
  assign b_arr[3]  = req.b_z;
  assign side_req  = {req.cmd, req.qa_w, req.qa_x, req.qa_y, req.qa_z};

  logic                   a_valid, a_ready;
  logic signed [P1_W-1:0] a_prod [4][4];
  logic [SD1_W-1:0]       a_side;

  qvr_mul_stage #(.A_W(FIELD_W), .B_W(FIELD_W), .SD_W(SD1_W)) u_mul1 (
    .clk(clk), .rst(rst),
    .in_valid(req_valid), .in_ready(req_ready),
    .a(qa_arr), .b(b_arr), .in_side(side_req),
    .out_valid(a_valid), .out_ready(a_ready),
    .prod(a_prod), .out_side(a_side)
  );

  logic                   b_valid, b_ready;
  logic signed [S1_W-1:0] b_sum [4];
  logic [SD1_W-1:0]       b_side;

  qvr_sum_stage #(.P_W(P1_W), .SD_W(SD1_W)) u_sum1 (
    .clk(clk), .rst(rst),
    .in_valid(a_valid), .in_ready(a_ready),
    .prod(a_prod), .in_side(a_side),
    .out_valid(b_valid), .out_ready(b_ready),
    .sum(b_sum), .out_side(b_side)
  );

  logic                 c_valid, c_ready;
  logic signed [TW-1:0] c_t [4];
  logic [SD1_W-1:0]     c_side;
  logic                 b_narrow;

  // a plain product saturates to the result width, the rotation keeps t wider
  assign b_narrow = (qvr_cmd_t'(b_side[SD1_W-1]) == CMD_PRODUCT);

  qvr_rnd_stage #(.S_W(S1_W), .F(QUAT_FRAC_BITS), .O_W(TW), .N_W(CW), .SD_W(SD1_W)) u_rnd1 (
    .clk(clk), .rst(rst),
    .in_valid(b_valid), .in_ready(b_ready),
    .sum(b_sum), .narrow(b_narrow), .in_side(b_side),
    .out_valid(c_valid), .out_ready(c_ready),
    .res(c_t), .out_side(c_side)
  );

  // second product t * conj(qa); -(-32768) stays exact in the wider word
  logic signed [CONJ_W-1:0] conj_arr [4];
  logic [SD2_W-1:0]         side_c;

  always_comb begin
    logic signed [FIELD_W-1:0] q;
    for (int i = 0; i < 4; i++) begin
      q = c_side[(3-i)*FIELD_W +: FIELD_W];
      if (i == 0) begin
        conj_arr[i] = CONJ_W'(q);
      end else begin
        conj_arr[i] = -CONJ_W'(q);
      end
    end
  end

  assign side_c = {c_side[SD1_W-1], c_t[0][CW-1:0], c_t[1][CW-1:0],
                   c_t[2][CW-1:0], c_t[3][CW-1:0]};

  logic                   d_valid, d_ready;
  logic signed [P2_W-1:0] d_prod [4][4];
  logic [SD2_W-1:0]       d_side;

  qvr_mul_stage #(.A_W(TW), .B_W(CONJ_W), .SD_W(SD2_W)) u_mul2 (
    .clk(clk), .rst(rst),
    .in_valid(c_valid), .in_ready(c_ready),
    .a(c_t), .b(conj_arr), .in_side(side_c),
    .out_valid(d_valid), .out_ready(d_ready),
    .prod(d_prod), .out_side(d_side)
  );

  logic                   e_valid, e_ready;
  logic signed [S2_W-1:0] e_sum [4];
  logic [SD2_W-1:0]       e_side;

  qvr_sum_stage #(.P_W(P2_W), .SD_W(SD2_W)) u_sum2 (
    .clk(clk), .rst(rst),
    .in_valid(d_valid), .in_ready(d_ready),
    .prod(d_prod), .in_side(d_side),
    .out_valid(e_valid), .out_ready(e_ready),
    .sum(e_sum), .out_side(e_side)
  );

  logic                 f_valid, f_ready;
  logic signed [CW-1:0] f_r [4];
  logic [SD2_W-1:0]     f_side;

  qvr_rnd_stage #(.S_W(S2_W), .F(QUAT_FRAC_BITS), .O_W(CW), .N_W(CW), .SD_W(SD2_W)) u_rnd2 (
    .clk(clk), .rst(rst),
    .in_valid(e_valid), .in_ready(e_ready),
    .sum(e_sum), .narrow(1'b0), .in_side(e_side),
    .out_valid(f_valid), .out_ready(f_ready),
    .res(f_r), .out_side(f_side)
  );

  // output register: pick the bypassed product or the rotated vector
  qvr_cmd_t             f_cmd;
  logic signed [CW-1:0] f_prod [4];
  qvr_rsp_t             rsp_next;
  logic                 rsp_valid_q;
  qvr_rsp_t             rsp_q;

  assign f_cmd = qvr_cmd_t'(f_side[SD2_W-1]);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      f_prod[i] = f_side[(3-i)*CW +: CW];
    end
    unique case (f_cmd)
      CMD_PRODUCT: begin
        rsp_next.r_w = FIELD_W'(f_prod[0]);
        rsp_next.r_x = FIELD_W'(f_prod[1]);
        rsp_next.r_y = FIELD_W'(f_prod[2]);
        rsp_next.r_z = FIELD_W'(f_prod[3]);
      end
      default: begin
        rsp_next.r_w = '0;
        rsp_next.r_x = FIELD_W'(f_r[1]);
        rsp_next.r_y = FIELD_W'(f_r[2]);
        rsp_next.r_z = FIELD_W'(f_r[3]);
      end
    endcase
  end

  assign f_ready   = !rsp_valid_q || rsp_ready;
  assign rsp_valid = rsp_valid_q;
  assign rsp       = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (f_ready) begin
      rsp_valid_q <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && f_valid) begin
      rsp_q <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_rot_w_zero: assert property (@(posedge clk) disable iff (rst)
    f_valid && f_ready && f_cmd == CMD_ROTATE |=> rsp_valid && rsp.r_w == '0)
    else $error("rotation word with nonzero w");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready && f_valid && c_valid && a_valid)
    else $error("request blocked while pipeline has a free stage");
`endif

endmodule

>>> hw/rtl/qvr_mul_stage.sv
`timescale 1ns / 1ps

module qvr_mul_stage #(
  parameter int A_W  = 16,
  parameter int B_W  = 16,
  parameter int SD_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [A_W-1:0]     a [4],
  input  logic signed [B_W-1:0]     b [4],
  input  logic [SD_W-1:0]           in_side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [A_W+B_W-1:0] prod [4][4],
  output logic [SD_W-1:0]           out_side
);

  logic                      valid_q;
  logic signed [A_W+B_W-1:0] prod_q [4][4];
  logic [SD_W-1:0]           side_q;

  assign in_ready  = !valid_q || out_ready;
  assign out_valid = valid_q;
  assign prod      = prod_q;
  assign out_side  = side_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  // all sixteen cross products, one multiplier each
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[i][j] <= a[i] * b[j];
        end
      end
      side_q <= in_side;
    end
  end

`ifndef SYNTHESIS
  a_mul_hold: assert property (@(posedge clk) disable iff (rst)
    valid_q && !out_ready |=> valid_q && $stable(prod_q[0][0]) && $stable(prod_q[3][3])
      && $stable(side_q))
    else $error("mul stage lost its word under stall");
`endif

endmodule

>>> hw/rtl/qvr_sum_stage.sv
`timescale 1ns / 1ps

module qvr_sum_stage #(
  parameter int P_W  = 32,
  parameter int SD_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [P_W-1:0] prod [4][4],
  input  logic [SD_W-1:0]       in_side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [P_W+1:0] sum [4],
  output logic [SD_W-1:0]       out_side
);

  logic                  valid_q;
  logic signed [P_W+1:0] sum_q [4];
  logic signed [P_W+1:0] sum_next [4];
  logic [SD_W-1:0]       side_q;

  assign in_ready  = !valid_q || out_ready;
  assign out_valid = valid_q;
  assign sum       = sum_q;
  assign out_side  = side_q;

  // hamilton sign pattern over a[i] * b[j]
  always_comb begin
    logic signed [P_W+1:0] e [4][4];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = (P_W+2)'(prod[i][j]);
      end
    end
    sum_next[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
    sum_next[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
    sum_next[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
    sum_next[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sum_q  <= sum_next;
      side_q <= in_side;
    end
  end

`ifndef SYNTHESIS
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    valid_q && !out_ready |=> valid_q && $stable(sum_q[0]) && $stable(sum_q[3])
      && $stable(side_q))
    else $error("sum stage lost its word under stall");
`endif

endmodule

>>> hw/rtl/qvr_rnd_stage.sv
`timescale 1ns / 1ps

module qvr_rnd_stage #(
  parameter int S_W  = 34,
  parameter int F    = 14,
  parameter int O_W  = 20,
  parameter int N_W  = 16,
  parameter int SD_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [S_W-1:0] sum [4],
  input  logic                  narrow,
  input  logic [SD_W-1:0]       in_side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [O_W-1:0] res [4],
  output logic [SD_W-1:0]       out_side
);

  localparam int V_W = S_W + 1 - F;
  localparam int E_W = ((V_W > O_W) ? V_W : O_W) + 1;
  localparam logic [S_W:0]   RND_BIAS  = (S_W+1)'(1) << (F - 1);
  localparam logic [E_W-1:0] WIDE_HI   = {{(E_W-O_W+1){1'b0}}, {(O_W-1){1'b1}}};
  localparam logic [E_W-1:0] WIDE_LO   = {{(E_W-O_W+1){1'b1}}, {(O_W-1){1'b0}}};
  localparam logic [E_W-1:0] NARROW_HI = {{(E_W-N_W+1){1'b0}}, {(N_W-1){1'b1}}};
  localparam logic [E_W-1:0] NARROW_LO = {{(E_W-N_W+1){1'b1}}, {(N_W-1){1'b0}}};

  logic                  valid_q;
  logic signed [O_W-1:0] res_q [4];
  logic signed [O_W-1:0] res_next [4];
  logic [SD_W-1:0]       side_q;

  assign in_ready  = !valid_q || out_ready;
  assign out_valid = valid_q;
  assign res       = res_q;
  assign out_side  = side_q;

  // round half up by floor((s + half) / 2^F), then clamp
  always_comb begin
    logic [S_W:0]          ext;
    logic signed [V_W-1:0] v;
    logic signed [E_W-1:0] ve;
    logic signed [E_W-1:0] lim_hi;
    logic signed [E_W-1:0] lim_lo;
    logic signed [E_W-1:0] clamped;
    lim_hi = narrow ? $signed(NARROW_HI) : $signed(WIDE_HI);
    lim_lo = narrow ? $signed(NARROW_LO) : $signed(WIDE_LO);
    for (int i = 0; i < 4; i++) begin
      ext = {sum[i][S_W-1], sum[i]} + RND_BIAS;
      v   = $signed(ext[S_W:F]);
      ve  = E_W'(v);
      priority if (ve > lim_hi) begin
        clamped = lim_hi;
      end else if (ve < lim_lo) begin
        clamped = lim_lo;
      end else begin
        clamped = ve;
      end
      res_next[i] = clamped[O_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_q  <= res_next;
      side_q <= in_side;
    end
  end

`ifndef SYNTHESIS
  a_rnd_hold: assert property (@(posedge clk) disable iff (rst)
    valid_q && !out_ready |=> valid_q && $stable(res_q[1]) && $stable(res_q[2])
      && $stable(side_q))
    else $error("round stage lost its word under stall");
`endif

endmodule
